// ===== rtl/core/case_insensitive_fnv1_hash_assert.svh =====
// Assertion macros for the FNV-1 hash block and its checker.
// Each macro samples on clk; the NEXT and IMPL forms are masked during rst.
`ifndef CASE_INSENSITIVE_FNV1_HASH_ASSERT_SVH
`define CASE_INSENSITIVE_FNV1_HASH_ASSERT_SVH

// ante holds in a cycle, cons holds in the next one
`define FNVH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fnvh: next-cycle check failed");

// ante and cons hold in the same cycle
`define FNVH_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fnvh: same-cycle check failed");

// checked also while reset is applied
`define FNVH_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fnvh: reset check failed");

`endif

// ===== rtl/core/fnvh_pkg.sv =====
package fnvh_pkg;

  localparam int HASH_W = 64;
  localparam int CHAR_W = 16;
  localparam int CFG_INDEX_W = 1;

  // FNV primes split as 2^shift + low part
  localparam int PRIME64_SHIFT = 40;
  localparam int PRIME32_SHIFT = 24;
  localparam logic [8:0] PRIME64_LO = 9'h1B3;
  localparam logic [8:0] PRIME32_LO = 9'h193;

  localparam logic [63:0] BASIS64 = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] BASIS32 = 64'h0000_0000_811C_9DC5;

  localparam logic [CFG_INDEX_W-1:0] REG_HASH_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_CHARS = 1'b1;

  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      r = c + 16'h0020;
    end
    return r;
  endfunction

  function automatic logic [63:0] basis_of(input logic wide_hash);
    return wide_hash ? BASIS64 : BASIS32;
  endfunction

endpackage

// ===== rtl/core/fnvh_mix.sv =====
module fnvh_mix (
  input  logic [63:0] hash_in,
  input  logic [7:0]  byte_in,
  input  logic        wide_hash,
  output logic [63:0] hash_out
);
  import fnvh_pkg::*;

  logic [8:0]  prime_lo;
  logic [63:0] shifted;
  logic [63:0] part;
  logic [63:0] prod;

  // h * prime = (h << shift) + h * low part; keep 32 bits in narrow mode
  always_comb begin
    prime_lo = wide_hash ? PRIME64_LO : PRIME32_LO;
    shifted  = wide_hash ? (hash_in << PRIME64_SHIFT) : (hash_in << PRIME32_SHIFT);
    part     = hash_in * {55'b0, prime_lo};
    prod     = shifted + part;
    if (!wide_hash) begin
      prod = {32'b0, prod[31:0]};
    end
    hash_out = prod ^ {56'b0, byte_in};
  end

endmodule

// ===== rtl/core/case_insensitive_fnv1_hash.sv =====
// Case-insensitive FNV-1 string hash, 32 or 64 bit.
// Characters arrive on the char channel (character, char_valid, char_stall);
// ASCII A-Z are folded to lower case before hashing. A zero character ends the
// string: the finished hash appears on the hash channel (hash_value,
// hash_valid, hash_stall) in the cycle after the terminator is taken, and the
// running hash reloads the offset basis.
// One shared prime multiplier (shift plus 64x9 constant multiply, then xor)
// does every byte. Narrow characters pass it once; wide characters pass it once per
// byte, low byte first, with char_stall high while the high byte is mixed.
// Registers: index 0 hash_width (0 = 32-bit, 1 = 64-bit; a write reloads the
// basis), index 1 wide_chars (0 = low byte only, 1 = low then high byte).
// Write them only while the block is idle.
// Reset clears both registers, loads the 32-bit basis and drops any result.
// When the receiver stalls, hash_value holds; char_stall is raised while a
// result waits and is stalled, so no further item is taken until it leaves.
module case_insensitive_fnv1_hash (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fnvh_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic                               cfg_data,
  input  logic [fnvh_pkg::CHAR_W-1:0]        character,
  input  logic                               char_valid,
  output logic                               char_stall,
  output logic [fnvh_pkg::HASH_W-1:0]        hash_value,
  output logic                               hash_valid,
  input  logic                               hash_stall
);
  import fnvh_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HIGH = 1'b1;

  logic              state;
  logic              hash_width;
  logic              wide_chars;
  logic [63:0]       running_hash;
  logic [7:0]        hi_byte;

  logic              char_take;
  logic [CHAR_W-1:0] char_masked;
  logic [CHAR_W-1:0] char_folded;
  logic [7:0]        mix_byte;
  logic [63:0]       mix_out;

  assign char_stall  = (state == ST_HIGH) || (hash_valid && hash_stall);
  assign char_take   = char_valid && !char_stall;
  assign char_masked = wide_chars ? character : {8'b0, character[7:0]};
  assign char_folded = fold_lower(char_masked);
  assign mix_byte    = (state == ST_HIGH) ? hi_byte : char_folded[7:0];

  fnvh_mix u_mix (
    .hash_in  (running_hash),
    .byte_in  (mix_byte),
    .wide_hash(hash_width),
    .hash_out (mix_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      hash_valid   <= 1'b0;
      hash_width   <= 1'b0;
      wide_chars   <= 1'b0;
      running_hash <= BASIS32;
    end else begin
      if (hash_valid && !hash_stall) begin
        hash_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (char_take) begin
            if (char_masked == '0) begin
              hash_valid   <= 1'b1;
              hash_value   <= hash_width ? running_hash : {32'b0, running_hash[31:0]};
              running_hash <= basis_of(hash_width);
            end else begin
              running_hash <= mix_out;
              hi_byte      <= char_folded[15:8];
              if (wide_chars) begin
                state <= ST_HIGH;
              end
            end
          end
        end
        ST_HIGH: begin
          running_hash <= mix_out;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_HASH_WIDTH: begin
            hash_width   <= cfg_data;
            running_hash <= basis_of(cfg_data);
          end
          REG_WIDE_CHARS: wide_chars <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/fnvh_checker.sv =====
`include "case_insensitive_fnv1_hash_assert.svh"

module fnvh_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic [fnvh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic                             cfg_data,
  input logic [fnvh_pkg::CHAR_W-1:0]      character,
  input logic                             char_valid,
  input logic                             char_stall,
  input logic [fnvh_pkg::HASH_W-1:0]      hash_value,
  input logic                             hash_valid,
  input logic                             hash_stall
);
  import fnvh_pkg::*;

  logic width_seen;
  logic wide_seen;
  logic char_take;

  assign char_take = char_valid && !char_stall;

  // track the registers as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      width_seen <= 1'b0;
      wide_seen  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_HASH_WIDTH) begin
        width_seen <= cfg_data;
      end
      if (cfg_index == REG_WIDE_CHARS) begin
        wide_seen <= cfg_data;
      end
    end
  end

  `FNVH_ASSERT_RST(a_reset_drops_result, rst, !hash_valid)
  `FNVH_ASSERT_NEXT(a_result_holds, hash_valid && hash_stall, hash_valid && $stable(hash_value))
  `FNVH_ASSERT_NEXT(a_terminator_emits, char_take && character == '0, hash_valid)
  `FNVH_ASSERT_NEXT(a_wide_takes_two, char_take && wide_seen && character != '0, char_stall)
  `FNVH_ASSERT_IMPL(a_narrow_upper_zero, hash_valid && !width_seen, hash_value[63:32] == '0)

endmodule

bind case_insensitive_fnv1_hash fnvh_checker u_fnvh_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .character (character),
  .char_valid(char_valid),
  .char_stall(char_stall),
  .hash_value(hash_value),
  .hash_valid(hash_valid),
  .hash_stall(hash_stall)
);
